/* rtl/cfcv_pkg.sv */
// ----------------------------------------------------------------------------
// cfcv_pkg
// shared types and constants of the csv frame checksum validator
// ----------------------------------------------------------------------------
package cfcv_pkg;

  localparam logic [7:0] COMMA_CHAR = 8'h2C;
  localparam logic [7:0] ZERO_CHAR  = 8'h00;
  localparam logic [7:0] DIGIT_LO   = 8'h30;
  localparam logic [7:0] DIGIT_HI   = 8'h39;
  localparam logic [1:0] TALLY_MAX  = 2'd2;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_CHECKSUM = 2'd1,
    STATUS_COMMAS   = 2'd2
  } status_t;

endpackage

/* rtl/cfcv_if.sv */
// ----------------------------------------------------------------------------
// cfcv_in_if / cfcv_out_if
// valid/ready channels for frame bytes and frame results
// ----------------------------------------------------------------------------
interface cfcv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       frame_end;

  modport source (output valid, output char_byte, output frame_end, input ready);
  modport sink   (input valid, input char_byte, input frame_end, output ready);
endinterface

interface cfcv_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] sequence_res;
  logic [7:0]  payload_start;
  logic [7:0]  payload_length;
  logic [31:0] malformed_total;

  modport source (output valid, output status, output sequence_res,
                  output payload_start, output payload_length,
                  output malformed_total, input ready);
  modport sink   (input valid, input status, input sequence_res,
                  input payload_start, input payload_length,
                  input malformed_total, output ready);
endinterface

/* rtl/cfcv_digit_acc.sv */
// ----------------------------------------------------------------------------
// cfcv_digit_acc
// saturating decimal accumulate: acc * 10 + digit, clamped to 32 bits
// ----------------------------------------------------------------------------
module cfcv_digit_acc (
  input  logic [31:0] acc,
  input  logic [3:0]  digit,
  output logic [31:0] acc_nxt
);

  logic [35:0] prod;

  always_comb begin
    prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'd0, digit};
    if (prod[35:32] != 4'd0) begin
      acc_nxt = '1;
    end else begin
      acc_nxt = prod[31:0];
    end
  end

endmodule

/* rtl/csv_frame_checksum_validator_top.sv */
// ----------------------------------------------------------------------------
// csv_frame_checksum_validator_top
// checks text frames "seq,payload,checksum" against a 16-bit byte sum
// ----------------------------------------------------------------------------
// in_ch carries one frame byte per request, frame_end on the last byte.
// out_ch carries one result per frame: status, sequence number, payload
// span and the running count of rejected frames.
// A byte is registered on acceptance and folded into the frame state from
// that register, so one byte per cycle is taken when out_ch keeps up.
// A result is registered once its frame_end byte leaves the input register
// and stays in the output register until out_ch.ready takes it.
// While the output register holds a result that is not taken, a pending
// frame_end byte waits in the input register and in_ch.ready drops; bytes
// that end no frame still move on.
// Bytes at positions MAX_LEN-1 and beyond are dropped; a zero byte ends the
// frame text. Reset (rst_n low, synchronous) clears the frame state, the
// reject counter and the valid flags of both channel registers.
// ----------------------------------------------------------------------------
module csv_frame_checksum_validator_top
  import cfcv_pkg::*;
#(
  parameter int MAX_LEN = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  cfcv_in_if.sink    in_ch,
  cfcv_out_if.source out_ch
);

  localparam int PW = $clog2(MAX_LEN);
  localparam int OW = (PW > 8) ? PW : 8;
  localparam logic [PW-1:0] POS_LIMIT = PW'(MAX_LEN - 1);

  // input register
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // frame state
  logic [PW-1:0] pos_r, pos_nxt;
  logic          ended_r, ended_nxt;
  logic [15:0]   sum_r, sum_nxt;
  logic [15:0]   sum_comma_r, sum_comma_nxt;
  logic [31:0]   tail_r, tail_nxt;
  logic          tail_stop_r, tail_stop_nxt;
  logic          tail_any_r, tail_any_nxt;
  logic [31:0]   lead_r, lead_nxt;
  logic          lead_stop_r, lead_stop_nxt;
  logic [1:0]    tally_r, tally_nxt;
  logic [PW-1:0] first_r, first_nxt;
  logic [PW-1:0] lastc_r, lastc_nxt;
  logic [31:0]   rejects_r, rejects_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  status_t     status_r, status_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [7:0]  start_r, start_nxt;
  logic [7:0]  length_r, length_nxt;
  logic [31:0] total_r, total_nxt;

  logic          out_free;
  logic          fire;
  logic          take;
  logic          is_digit;
  logic [31:0]   tail_acc;
  logic [31:0]   lead_acc;
  logic [OW-1:0] first_ext;
  logic [OW-1:0] lastc_ext;
  logic [OW-1:0] start_ext;
  logic [OW-1:0] length_ext;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign fire        = in_valid_r && (!in_last_r || out_free);
  assign in_ch.ready = !in_valid_r || fire;

  assign is_digit = (in_byte_r >= DIGIT_LO) && (in_byte_r <= DIGIT_HI);

  cfcv_digit_acc u_tail_acc (
    .acc     (tail_r),
    .digit   (in_byte_r[3:0]),
    .acc_nxt (tail_acc)
  );

  cfcv_digit_acc u_lead_acc (
    .acc     (lead_r),
    .digit   (in_byte_r[3:0]),
    .acc_nxt (lead_acc)
  );

  always_comb begin
    in_valid_nxt  = in_valid_r;
    pos_nxt       = pos_r;
    ended_nxt     = ended_r;
    sum_nxt       = sum_r;
    sum_comma_nxt = sum_comma_r;
    tail_nxt      = tail_r;
    tail_stop_nxt = tail_stop_r;
    tail_any_nxt  = tail_any_r;
    lead_nxt      = lead_r;
    lead_stop_nxt = lead_stop_r;
    tally_nxt     = tally_r;
    first_nxt     = first_r;
    lastc_nxt     = lastc_r;
    rejects_nxt   = rejects_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    seq_nxt       = seq_r;
    start_nxt     = start_r;
    length_nxt    = length_r;
    total_nxt     = total_r;
    take          = !ended_r && (pos_r < POS_LIMIT);
    first_ext     = '0;
    lastc_ext     = '0;
    start_ext     = '0;
    length_ext    = '0;

    if (fire) begin
      in_valid_nxt = 1'b0;
    end
    if (in_ch.valid && in_ch.ready) begin
      in_valid_nxt = 1'b1;
    end

    if (fire && take) begin
      if (in_byte_r == ZERO_CHAR) begin
        ended_nxt = 1'b1;
      end else begin
        if (in_byte_r == COMMA_CHAR) begin
          sum_comma_nxt = sum_r;
          lastc_nxt     = pos_r;
          if (tally_r == 2'd0) begin
            first_nxt = pos_r;
          end
          if (tally_r < TALLY_MAX) begin
            tally_nxt = tally_r + 2'd1;
          end
          tail_nxt      = '0;
          tail_stop_nxt = 1'b0;
          tail_any_nxt  = 1'b0;
          lead_stop_nxt = 1'b1;
        end else begin
          tail_any_nxt = 1'b1;
          if (!tail_stop_r) begin
            if (is_digit) begin
              tail_nxt = tail_acc;
            end else begin
              tail_stop_nxt = 1'b1;
            end
          end
          if (!lead_stop_r) begin
            if (is_digit) begin
              lead_nxt = lead_acc;
            end else begin
              lead_stop_nxt = 1'b1;
            end
          end
        end
        sum_nxt = sum_r + {{8{in_byte_r[7]}}, in_byte_r};
        pos_nxt = pos_r + PW'(1);
      end
    end

    if (fire && in_last_r) begin
      if (tally_nxt == 2'd0 || !tail_any_nxt) begin
        status_nxt = STATUS_CHECKSUM;
      end else if (tail_nxt[15:0] != sum_comma_nxt) begin
        status_nxt = STATUS_CHECKSUM;
      end else if (tally_nxt < TALLY_MAX) begin
        status_nxt = STATUS_COMMAS;
      end else begin
        status_nxt = STATUS_OK;
      end

      first_ext  = OW'(first_nxt);
      lastc_ext  = OW'(lastc_nxt);
      start_ext  = first_ext + OW'(1);
      length_ext = lastc_ext - first_ext - OW'(1);

      if (status_nxt == STATUS_OK) begin
        seq_nxt    = lead_nxt;
        start_nxt  = start_ext[7:0];
        length_nxt = length_ext[7:0];
      end else begin
        rejects_nxt = rejects_r + 32'd1;
        seq_nxt     = '0;
        start_nxt   = '0;
        length_nxt  = '0;
      end
      total_nxt     = rejects_nxt;
      out_valid_nxt = 1'b1;

      pos_nxt       = '0;
      ended_nxt     = 1'b0;
      sum_nxt       = '0;
      sum_comma_nxt = '0;
      tail_nxt      = '0;
      tail_stop_nxt = 1'b0;
      tail_any_nxt  = 1'b0;
      lead_nxt      = '0;
      lead_stop_nxt = 1'b0;
      tally_nxt     = '0;
      first_nxt     = '0;
      lastc_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      pos_r       <= '0;
      ended_r     <= 1'b0;
      sum_r       <= '0;
      sum_comma_r <= '0;
      tail_r      <= '0;
      tail_stop_r <= 1'b0;
      tail_any_r  <= 1'b0;
      lead_r      <= '0;
      lead_stop_r <= 1'b0;
      tally_r     <= '0;
      first_r     <= '0;
      lastc_r     <= '0;
      rejects_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      pos_r       <= pos_nxt;
      ended_r     <= ended_nxt;
      sum_r       <= sum_nxt;
      sum_comma_r <= sum_comma_nxt;
      tail_r      <= tail_nxt;
      tail_stop_r <= tail_stop_nxt;
      tail_any_r  <= tail_any_nxt;
      lead_r      <= lead_nxt;
      lead_stop_r <= lead_stop_nxt;
      tally_r     <= tally_nxt;
      first_r     <= first_nxt;
      lastc_r     <= lastc_nxt;
      rejects_r   <= rejects_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.char_byte;
      in_last_r <= in_ch.frame_end;
    end
    status_r <= status_nxt;
    seq_r    <= seq_nxt;
    start_r  <= start_nxt;
    length_r <= length_nxt;
    total_r  <= total_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = status_r;
  assign out_ch.sequence_res    = seq_r;
  assign out_ch.payload_start   = start_r;
  assign out_ch.payload_length  = length_r;
  assign out_ch.malformed_total = total_r;

endmodule
